// File: rtl/flp_pkg.sv
// ----------------------------------------------------------------------------
// flp_pkg: shared types and constants of the four-pole resonant lowpass
// Field widths, fixed-point constants, coefficient bundle, sequencer codes
// and the 32-bit saturation used by the head and the stage cells.
// ----------------------------------------------------------------------------
package flp_pkg;

  localparam int DEFAULT_CHANNELS = 8;
  localparam int STAGES           = 4;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int CUTOFF_W = 22;
  localparam int RES_W    = 23;
  localparam int FB_W     = 26;
  localparam int GPART_W  = 20;
  localparam int OMF_W    = 23;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 22'd173300;
  localparam logic [RES_W-1:0]    RES_RESET    = 23'd65536;
  localparam logic [RES_W-1:0]    RES_MIN      = 23'd655;

  // q0.20 and q0.24 coefficient constants
  localparam logic [19:0] K_03  = 20'd314573;
  localparam logic [17:0] K_015 = 18'd157286;
  localparam logic [16:0] K_01  = 17'd104858;
  localparam logic [22:0] K_G   = 23'd5873916;

  typedef struct packed {
    logic signed [FB_W-1:0]  fb;
    logic [GPART_W-1:0]      g_hi;
    logic [GPART_W-1:0]      g_lo;
    logic signed [OMF_W-1:0] omf;
  } coef_t;

  typedef enum logic [3:0] {
    CS_FSQ,
    CS_RESK,
    CS_F4,
    CS_C1,
    CS_GLO,
    CS_FB,
    CS_GHI,
    CS_GSUM,
    CS_IDLE
  } coef_step_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_BUSY,
    CTL_DONE
  } ctl_state_t;

  typedef enum logic {
    REG_CUTOFF    = 1'b0,
    REG_RESONANCE = 1'b1
  } reg_idx_t;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] v);
    if (v[63:STATE_W-1] == {(64-STATE_W+1){v[63]}}) begin
      return v[STATE_W-1:0];
    end else if (v[63]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/flp_ifs.sv
// ----------------------------------------------------------------------------
// flp_ifs: item channels of the four-pole resonant lowpass
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface flp_sample_if;
  logic                                valid;
  logic                                ready;
  logic [flp_pkg::CHAN_W-1:0]          chan;
  logic signed [flp_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, chan, sample_in, input ready);
  modport sink (input valid, chan, sample_in, output ready);
endinterface

interface flp_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [flp_pkg::SAMPLE_W-1:0] sample_out;
  logic [flp_pkg::CHAN_W-1:0]          out_chan;

  modport source (output valid, sample_out, out_chan, input ready);
  modport sink (input valid, sample_out, out_chan, output ready);
endinterface

// File: rtl/flp_coef.sv
// ----------------------------------------------------------------------------
// flp_coef: coefficient derivation
// Derives fb, g and 1-f from the cutoff and resonance registers with one
// shared multiplier, one product per cycle.
// ----------------------------------------------------------------------------
module flp_coef (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [flp_pkg::CUTOFF_W-1:0]   cutoff,
  input  logic [flp_pkg::RES_W-1:0]      resonance,
  output logic                           busy,
  output flp_pkg::coef_t                 coef
);

  flp_pkg::coef_step_t step;
  flp_pkg::coef_step_t step_next;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] p;

  logic [31:0]        fsq28;
  logic [23:0]        fsq20;
  logic [23:0]        deci;
  logic [39:0]        f4;
  logic signed [21:0] c1;
  logic [42:0]        plo;
  flp_pkg::coef_t     coef_q;

  logic [flp_pkg::RES_W-1:0] res_clamped;

  logic [44:0]        fsq_sum;
  logic [31:0]        fsq28_c;
  logic [32:0]        fsq20_sum;
  logic [40:0]        deci_sum;
  logic [64:0]        f4_sum;
  logic [42:0]        c1_sum;
  logic signed [23:0] c1_c;
  logic signed [65:0] fb_sum;
  logic [63:0]        g_sum;

  assign res_clamped = (resonance < flp_pkg::RES_MIN) ? flp_pkg::RES_MIN : resonance;
  assign busy = (step != flp_pkg::CS_IDLE);
  assign coef = coef_q;

  always_comb begin
    step_next = step;
    unique case (step)
      flp_pkg::CS_FSQ:  step_next = flp_pkg::CS_RESK;
      flp_pkg::CS_RESK: step_next = flp_pkg::CS_F4;
      flp_pkg::CS_F4:   step_next = flp_pkg::CS_C1;
      flp_pkg::CS_C1:   step_next = flp_pkg::CS_GLO;
      flp_pkg::CS_GLO:  step_next = flp_pkg::CS_FB;
      flp_pkg::CS_FB:   step_next = flp_pkg::CS_GHI;
      flp_pkg::CS_GHI:  step_next = flp_pkg::CS_GSUM;
      flp_pkg::CS_GSUM: step_next = flp_pkg::CS_IDLE;
      flp_pkg::CS_IDLE: step_next = flp_pkg::CS_IDLE;
      default:          step_next = flp_pkg::CS_IDLE;
    endcase
    if (start) begin
      step_next = flp_pkg::CS_FSQ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= flp_pkg::CS_FSQ;
    end else begin
      step <= step_next;
    end
  end

  // steps FSQ to GHI each issue one product; steps RESK to GSUM store the product of the step before
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      flp_pkg::CS_FSQ: begin
        mul_a = $signed(33'(cutoff));
        mul_b = $signed(33'(cutoff));
      end
      flp_pkg::CS_RESK: begin
        mul_a = $signed(33'(res_clamped));
        mul_b = $signed(33'(flp_pkg::K_01));
      end
      flp_pkg::CS_F4: begin
        mul_a = $signed(33'(fsq28));
        mul_b = $signed(33'(fsq28));
      end
      flp_pkg::CS_C1: begin
        mul_a = $signed(33'(fsq20));
        mul_b = $signed(33'(flp_pkg::K_015));
      end
      flp_pkg::CS_GLO: begin
        mul_a = $signed(33'(f4[19:0]));
        mul_b = $signed(33'(flp_pkg::K_G));
      end
      flp_pkg::CS_FB: begin
        mul_a = $signed(33'(deci));
        mul_b = 33'(c1);
      end
      flp_pkg::CS_GHI: begin
        mul_a = $signed(33'(f4[39:20]));
        mul_b = $signed(33'(flp_pkg::K_G));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    fsq_sum   = p[44:0] + 45'd2048;
    fsq28_c   = fsq_sum[43:12];
    fsq20_sum = {1'b0, fsq28_c} + 33'd128;
    deci_sum  = p[40:0] + 41'd32768;
    f4_sum    = {1'b0, p[63:0]} + 65'h800000;
    c1_sum    = p[42:0] + 43'd524288;
    c1_c      = 24'sd1048576 - $signed({1'b0, c1_sum[42:20]});
    fb_sum    = p + 66'sd524288;
    g_sum     = {1'b0, p[42:0], 20'b0} + {21'b0, plo} + 64'h800000;
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    unique case (step)
      flp_pkg::CS_RESK: begin
        fsq28 <= fsq28_c;
        fsq20 <= fsq20_sum[31:8];
        coef_q.omf <= 23'sd1048576 - $signed({1'b0, cutoff});
      end
      flp_pkg::CS_F4:   deci <= deci_sum[39:16];
      flp_pkg::CS_C1:   f4 <= f4_sum[63:24];
      flp_pkg::CS_GLO:  c1 <= c1_c[21:0];
      flp_pkg::CS_FB:   plo <= p[42:0];
      flp_pkg::CS_GHI:  coef_q.fb <= fb_sum[45:20];
      flp_pkg::CS_GSUM: begin
        coef_q.g_hi <= g_sum[63:44];
        coef_q.g_lo <= g_sum[43:24];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/flp_head.sv
// ----------------------------------------------------------------------------
// flp_head: feedback and input gain
// Subtracts y4*fb from the sample and scales the difference by g, using one
// multiplier over three products; hands the result to the first stage cell.
// ----------------------------------------------------------------------------
module flp_head (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [flp_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [flp_pkg::STATE_W-1:0]   y4,
  input  flp_pkg::coef_t                       coef,
  output logic                                 t_valid,
  output logic signed [flp_pkg::STATE_W-1:0]   t_out
);

  logic v1;
  logic v2;
  logic v3;
  logic v4;

  logic signed [31:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [57:0] p;

  logic signed [31:0] t0;
  logic signed [37:0] alo;

  logic signed [57:0] fbk_sum;
  logic signed [37:0] fbk;
  logic signed [63:0] diff;
  logic signed [57:0] alo_sum;
  logic signed [57:0] hs;
  logic signed [45:0] hq;

  always_comb begin
    mul_a = y4;
    mul_b = coef.fb;
    if (v2) begin
      mul_a = t0;
      mul_b = $signed(flp_pkg::FB_W'(coef.g_lo));
    end else if (v3) begin
      mul_a = t0;
      mul_b = $signed(flp_pkg::FB_W'(coef.g_hi));
    end
  end

  always_comb begin
    fbk_sum = p + 58'sd524288;
    fbk     = fbk_sum[57:20];
    diff    = 64'(sample) - 64'(fbk);
    alo_sum = p + 58'sd2147483648;
    hs      = p + 58'(alo);
    hq      = hs[57:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      t_valid <= 1'b0;
    end else begin
      v1      <= start;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      t_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (v1) begin
      t0 <= flp_pkg::sat32(diff);
    end
    if (v3) begin
      alo <= alo_sum[57:20];
    end
    if (v4) begin
      t_out <= flp_pkg::sat32(64'(hq));
    end
  end

endmodule

// File: rtl/flp_cell.sv
// ----------------------------------------------------------------------------
// flp_cell: one-pole stage cell
// Holds the per-channel history of one stage and computes
// y = in + 0.3*prev_in + (1-f)*y with one multiplier.
// ----------------------------------------------------------------------------
module flp_cell #(
  parameter int CHANNELS = flp_pkg::DEFAULT_CHANNELS,
  parameter int AW       = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  input  logic                                t_valid_in,
  input  logic signed [flp_pkg::STATE_W-1:0]  t_in,
  input  logic signed [flp_pkg::OMF_W-1:0]    omf,
  output logic signed [flp_pkg::STATE_W-1:0]  y_rd,
  output logic                                t_valid_out,
  output logic signed [flp_pkg::STATE_W-1:0]  t_out
);

  logic [2*flp_pkg::STATE_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]           vld;

  logic [2*flp_pkg::STATE_W-1:0] rd_data;
  logic                          rd_vld;
  logic [AW-1:0]                 addr_q;

  logic v1;
  logic v2;

  logic signed [31:0] prev_s;
  logic signed [31:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [54:0] p;
  logic signed [31:0] t_q;
  logic signed [56:0] acc;
  logic signed [56:0] rsum;
  logic signed [36:0] rs;
  logic signed [31:0] ny;

  // entries never written since reset read as zero
  assign prev_s = rd_vld ? rd_data[63:32] : '0;
  assign y_rd   = rd_vld ? rd_data[31:0] : '0;

  always_comb begin
    mul_a = prev_s;
    mul_b = $signed(flp_pkg::OMF_W'(flp_pkg::K_03));
    if (v1) begin
      mul_a = y_rd;
      mul_b = omf;
    end
  end

  always_comb begin
    rsum = acc + 57'(p) + 57'sd524288;
    rs   = rsum[56:20];
    ny   = flp_pkg::sat32(64'(rs));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      rd_vld      <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      t_valid_out <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
      if (v2) begin
        vld[addr_q] <= 1'b1;
      end
      v1          <= t_valid_in;
      v2          <= v1;
      t_valid_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      addr_q  <= rd_addr;
    end
    if (v2) begin
      mem[addr_q] <= {t_q, ny};
    end
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (t_valid_in) begin
      t_q <= t_in;
    end
    if (v1) begin
      acc <= 57'(p) + (57'(t_q) <<< 20);
    end
    if (v2) begin
      t_out <= ny;
    end
  end

endmodule

// File: rtl/four_pole_resonant_lowpass.sv
// ----------------------------------------------------------------------------
// four_pole_resonant_lowpass: multichannel four-pole resonant lowpass
// Feedback head followed by a row of four one-pole stage cells, each cell
// keeping its stage's history for every channel.
//
//   port       | dir  | handshake      | payload
//   -----------+------+----------------+------------------------------
//   sample_ch  | sink | valid/ready    | chan, sample_in
//   result_ch  | src  | valid/ready    | sample_out, out_chan
//   apb        | sink | psel/penable   | paddr, pwdata, prdata
//
// An item runs through the head (three products on its multiplier) and then
// the four cells one after another, plus read and hand-off; the next item is
// taken only once the control is idle again. An item on a channel at or above
// CHANNELS skips the head and cells and gives a zero result.
// After reset and after each register write the coefficient unit runs with
// sample_ch.ready low. Reset clears the history at once through
// per-entry valid bits. The output register holds a result while the sink
// stalls; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module four_pole_resonant_lowpass #(
  parameter int CHANNELS = flp_pkg::DEFAULT_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  flp_sample_if.sink                   sample_ch,
  flp_result_if.source                 result_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flp_pkg::APB_AW-1:0]   paddr,
  input  logic [flp_pkg::APB_DW-1:0]   pwdata,
  output logic [flp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // one bit above the address so that CHANNELS itself fits in the compare
  localparam int WIDE_W = ((AW + 1) > flp_pkg::CHAN_W) ? (AW + 1) : flp_pkg::CHAN_W;

  logic [flp_pkg::CUTOFF_W-1:0] cutoff_coef;
  logic [flp_pkg::RES_W-1:0]    resonance;
  logic                         wr_en;
  flp_pkg::reg_idx_t            reg_idx;

  logic           coef_busy;
  flp_pkg::coef_t coef;

  flp_pkg::ctl_state_t state;
  flp_pkg::ctl_state_t state_next;

  logic                                accept;
  logic [WIDE_W-1:0]                   chan_wide;
  logic                                chan_ok;
  logic                                rd_en;
  logic                                start;
  logic signed [flp_pkg::SAMPLE_W-1:0] sample_q;
  logic [flp_pkg::CHAN_W-1:0]          chan_q;
  logic signed [flp_pkg::SAMPLE_W-1:0] res_q;
  logic signed [flp_pkg::SAMPLE_W-1:0] y_sat;
  logic                                out_free;

  logic                                out_valid;
  logic signed [flp_pkg::SAMPLE_W-1:0] out_sample;
  logic [flp_pkg::CHAN_W-1:0]          out_chan_q;

  logic                               t_valid [flp_pkg::STAGES+1];
  logic signed [flp_pkg::STATE_W-1:0] t_bus   [flp_pkg::STAGES+1];
  logic signed [flp_pkg::STATE_W-1:0] y_rd    [flp_pkg::STAGES];

  // register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = flp_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      flp_pkg::REG_CUTOFF:    prdata = flp_pkg::APB_DW'(cutoff_coef);
      flp_pkg::REG_RESONANCE: prdata = flp_pkg::APB_DW'(resonance);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_coef <= flp_pkg::CUTOFF_RESET;
      resonance   <= flp_pkg::RES_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        flp_pkg::REG_CUTOFF:    cutoff_coef <= pwdata[flp_pkg::CUTOFF_W-1:0];
        flp_pkg::REG_RESONANCE: resonance <= pwdata[flp_pkg::RES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  flp_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .start     (wr_en),
    .cutoff    (cutoff_coef),
    .resonance (resonance),
    .busy      (coef_busy),
    .coef      (coef)
  );

  // item control
  assign chan_wide       = WIDE_W'(sample_ch.chan);
  assign chan_ok         = (chan_wide < WIDE_W'(CHANNELS));
  assign sample_ch.ready = (state == flp_pkg::CTL_IDLE) && !coef_busy;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign rd_en           = accept && chan_ok;
  assign out_free        = !out_valid || result_ch.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      flp_pkg::CTL_IDLE: begin
        if (accept) begin
          state_next = chan_ok ? flp_pkg::CTL_BUSY : flp_pkg::CTL_DONE;
        end
      end
      flp_pkg::CTL_BUSY: begin
        if (t_valid[flp_pkg::STAGES]) begin
          state_next = flp_pkg::CTL_DONE;
        end
      end
      flp_pkg::CTL_DONE: begin
        if (out_free) begin
          state_next = flp_pkg::CTL_IDLE;
        end
      end
      default: state_next = flp_pkg::CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= flp_pkg::CTL_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= rd_en;
      if (state == flp_pkg::CTL_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output saturation to q1.23
  always_comb begin
    if (t_bus[flp_pkg::STAGES][31:23] == {9{t_bus[flp_pkg::STAGES][31]}}) begin
      y_sat = t_bus[flp_pkg::STAGES][23:0];
    end else if (t_bus[flp_pkg::STAGES][31]) begin
      y_sat = {1'b1, {(flp_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(flp_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_ch.sample_in;
      chan_q   <= sample_ch.chan;
      if (!chan_ok) begin
        res_q <= '0;
      end
    end
    if (state == flp_pkg::CTL_BUSY && t_valid[flp_pkg::STAGES]) begin
      res_q <= y_sat;
    end
    if (state == flp_pkg::CTL_DONE && out_free) begin
      out_sample <= res_q;
      out_chan_q <= chan_q;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.sample_out = out_sample;
  assign result_ch.out_chan   = out_chan_q;

  // feedback head and stage row
  flp_head u_head (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .sample  (sample_q),
    .y4      (y_rd[flp_pkg::STAGES-1]),
    .coef    (coef),
    .t_valid (t_valid[0]),
    .t_out   (t_bus[0])
  );

  for (genvar k = 0; k < flp_pkg::STAGES; k++) begin : g_stage
    flp_cell #(
      .CHANNELS (CHANNELS),
      .AW       (AW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .rd_en       (rd_en),
      .rd_addr     (chan_wide[AW-1:0]),
      .t_valid_in  (t_valid[k]),
      .t_in        (t_bus[k]),
      .omf         (coef.omf),
      .y_rd        (y_rd[k]),
      .t_valid_out (t_valid[k+1]),
      .t_out       (t_bus[k+1])
    );
  end

endmodule

// File: rtl/flp_chk.sv
// ----------------------------------------------------------------------------
// flp_chk: port-level checks of the four-pole resonant lowpass
// Watches the item channels and the register port of the top level.
// ----------------------------------------------------------------------------
module flp_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [flp_pkg::SAMPLE_W-1:0] sample_out,
  input logic [flp_pkg::CHAN_W-1:0]          out_chan,
  input logic                                cfg_wr
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(out_chan))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in flight");

  // coefficients are rebuilt after a register write
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !in_ready)
    else $error("item taken during coefficient update");

  // coefficients are built after reset
  a_rst_hold: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item taken before coefficients are ready");

endmodule

bind four_pole_resonant_lowpass flp_chk u_flp_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_ch.valid),
  .in_ready   (sample_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .sample_out (result_ch.sample_out),
  .out_chan   (result_ch.out_chan),
  .cfg_wr     (psel && penable && pwrite && pready)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the four-pole resonant lowpass
// Samples go in over the valid/ready channel and each filtered result is
// checked against a fixed-point ladder filter kept in the bench, with its own
// per-channel history and coefficients. Register writes go through the APB
// port between phases. Directed extremes come first, then random phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_CH        = flp_pkg::DEFAULT_CHANNELS;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 30;
  localparam int N_PHASES    = 7;
  localparam int PHASE_ITEMS = 100;

  localparam longint unsigned FLOOR_RES  = 655;
  localparam longint unsigned Q20_TENTH  = 104858;
  localparam longint unsigned Q20_K015   = 157286;
  localparam longint unsigned Q24_GAIN   = 5873916;
  localparam longint          Q20_K03    = 314573;
  localparam longint          Q20_ONE    = 64'sd1 <<< 20;

  localparam logic [21:0] CUTOFF_TOP = 22'h3fffff;
  localparam logic [22:0] RES_TOP    = 23'h7fffff;

  typedef struct {
    logic signed [23:0] y;
    logic [2:0]         ch;
  } filtered_t;

  class ladder_scoreboard;
    logic [21:0] cutoff;
    logic [22:0] res_reg;
    longint      fb;
    longint      g;
    longint      omf;
    int          prev_in [N_CH][4];
    int          stage_y [N_CH][4];
    filtered_t   filtered_due [$];
    int          errors;

    function new();
      cutoff  = 22'd173300;
      res_reg = 23'd65536;
      errors  = 0;
      foreach (prev_in[c, k]) begin
        prev_in[c][k] = 0;
        stage_y[c][k] = 0;
      end
      load_coefs();
    endfunction

    function longint rnd_shift(longint x, int sh);
      return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void load_coefs();
      longint unsigned f;
      longint unsigned r;
      longint unsigned fsq28;
      longint unsigned fsq20;
      longint unsigned f4;
      longint          deci;
      longint          c1;
      f     = cutoff;
      // low resonance is clipped up to the floor
      r     = (res_reg < FLOOR_RES) ? FLOOR_RES : res_reg;
      fsq28 = (f * f + 64'd2048) >> 12;
      fsq20 = (fsq28 + 64'd128) >> 8;
      f4    = (fsq28 * fsq28 + (64'd1 << 23)) >> 24;
      deci  = longint'((r * Q20_TENTH + 64'd32768) >> 16);
      c1    = Q20_ONE - longint'((fsq20 * Q20_K015 + (64'd1 << 19)) >> 20);
      fb    = rnd_shift(deci * c1, 20);
      g     = longint'((f4 * Q24_GAIN + (64'd1 << 23)) >> 24);
      omf   = Q20_ONE - longint'(f);
    endfunction

    function void set_reg(flp_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        flp_pkg::REG_CUTOFF: begin
          cutoff = v[21:0];
        end
        flp_pkg::REG_RESONANCE: begin
          res_reg = v[22:0];
        end
        default: begin
        end
      endcase
      load_coefs();
    endfunction

    function void take_sample(logic [2:0] ch, logic signed [23:0] x);
      longint                t;
      longint                acc;
      logic signed [127:0]   tw;
      logic signed [127:0]   gw;
      logic signed [127:0]   scaled;
      int                    ny;
      int                    y;
      filtered_t             e;
      e.ch = ch;
      e.y  = '0;
      if (int'(ch) < N_CH) begin
        t  = clamp32(longint'(x) - rnd_shift(longint'(stage_y[ch][3]) * fb, 20));
        tw = t;
        gw = g;
        scaled = (tw * gw + (128'sd1 <<< 31)) >>> 32;
        t  = clamp32(longint'(scaled));
        for (int k = 0; k < 4; k++) begin
          acc = t * Q20_ONE + longint'(prev_in[ch][k]) * Q20_K03
              + longint'(stage_y[ch][k]) * omf;
          ny = clamp32(rnd_shift(acc, 20));
          prev_in[ch][k] = int'(t);
          stage_y[ch][k] = ny;
          t = ny;
        end
        y = stage_y[ch][3];
        if (y > 8388607) e.y = 24'sh7fffff;
        else if (y < -8388608) e.y = 24'sh800000;
        else e.y = y[23:0];
      end
      filtered_due.push_back(e);
    endfunction

    function void check_result(logic signed [23:0] y, logic [2:0] ch);
      filtered_t e;
      if (filtered_due.size() == 0) begin
        $error("result with no item pending: sample_out %0d, out_chan %0d", y, ch);
        errors++;
        return;
      end
      e = filtered_due.pop_front();
      if (y !== e.y) begin
        $error("sample_out: expected %0d, actual %0d", e.y, y);
        errors++;
      end
      if (ch !== e.ch) begin
        $error("out_chan: expected %0d, actual %0d", e.ch, ch);
        errors++;
      end
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction

    function void flush_leftover();
      while (filtered_due.size() > 0) begin
        filtered_t e;
        e = filtered_due.pop_front();
        $error("sample_out: expected %0d, actual none (out_chan %0d)", e.y, e.ch);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  flp_sample_if sample_ch ();
  flp_result_if result_ch ();

  four_pole_resonant_lowpass u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ladder_scoreboard sb = new();

  bit steady;
  bit moved;
  int quiet;
  int n_items;
  int n_results;
  int n_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= 20);
  end

  // input and result monitor, plus the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (sample_ch.valid && sample_ch.ready) begin
        sb.take_sample(sample_ch.chan, sample_ch.sample_in);
        n_items++;
        moved = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        sb.check_result(result_ch.sample_out, result_ch.out_chan);
        n_results++;
        moved = 1'b1;
      end
      if (psel && penable) moved = 1'b1;
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results pending", quiet, sb.pending());
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic [2:0] ch, input logic signed [23:0] x);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 20) gap++;
    end
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.chan      <= ch;
    sample_ch.sample_in <= x;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input flp_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    n_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_sample();
    logic signed [23:0] x;
    x = 24'($urandom);
    case ($urandom_range(9))
      0: x = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      1, 2, 3: begin
      end
      default: x = x >>> $urandom_range(16, 4);
    endcase
    return x;
  endfunction

  initial begin
    logic signed [23:0] edge_vals [8];
    logic [21:0]        cut;
    logic [22:0]        res;

    edge_vals = '{24'sh7fffff, 24'sh800000, 24'sh000000, 24'shffffff,
                  24'sh000001, 24'sh7fffff, 24'sh800000, 24'sh400000};
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.chan      <= '0;
    sample_ch.sample_in <= '0;
    steady    = 1'b0;
    quiet     = 0;
    n_items   = 0;
    n_results = 0;
    n_writes  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients, every channel, full-scale, zero and small edge samples
    for (int c = 0; c < 8; c++) push_sample(c[2:0], edge_vals[c]);
    drain();

    // full-scale cutoff and resonance: unstable, stages saturate
    write_reg(flp_pkg::REG_CUTOFF, {10'd0, CUTOFF_TOP});
    write_reg(flp_pkg::REG_RESONANCE, {9'd0, RES_TOP});
    push_sample(3'd0, 24'sh7fffff);
    push_sample(3'd0, 24'sh7fffff);
    push_sample(3'd1, 24'sh800000);
    push_sample(3'd1, 24'sh800000);
    push_sample(3'd2, 24'sh7fffff);
    push_sample(3'd0, 24'sh000000);
    drain();

    // zero cutoff, resonance below the floor
    write_reg(flp_pkg::REG_CUTOFF, 32'd0);
    write_reg(flp_pkg::REG_RESONANCE, 32'd0);
    push_sample(3'd3, 24'sh7fffff);
    push_sample(3'd3, 24'sh800000);
    push_sample(3'd4, 24'sh123456);
    push_sample(3'd3, 24'sh000000);
    drain();

    // unity cutoff, resonance right at the floor
    write_reg(flp_pkg::REG_CUTOFF, 32'd1048576);
    write_reg(flp_pkg::REG_RESONANCE, 32'd655);
    push_sample(3'd5, 24'sh800000);
    push_sample(3'd6, 24'sh7fffff);
    push_sample(3'd5, 24'shffffff);
    push_sample(3'd7, 24'sh000001);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case ($urandom_range(5))
        0: cut = $urandom_range(1) ? CUTOFF_TOP : 22'd0;
        default: cut = 22'($urandom_range(1500000, 2000));
      endcase
      case ($urandom_range(5))
        0: res = 23'($urandom_range(654));
        1: res = $urandom_range(1) ? RES_TOP : 23'd6553600;
        default: res = 23'($urandom_range(300000, 655));
      endcase
      // upper bits of the write data carry junk the block must drop
      write_reg(flp_pkg::REG_CUTOFF, {10'($urandom), cut});
      write_reg(flp_pkg::REG_RESONANCE, {9'($urandom), res});
      steady = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_sample(3'($urandom_range(7)), pick_sample());
      end
      steady = 1'b0;
      drain();
    end

    sb.flush_leftover();
    $display("%0d samples filtered and %0d results checked, %0d register writes",
             n_items, n_results, n_writes);
    $display("settings spanned zero and full-scale cutoff, clipped and top resonance");
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: four_pole_resonant_lowpass.f
rtl/flp_pkg.sv
rtl/flp_ifs.sv
rtl/flp_coef.sv
rtl/flp_head.sv
rtl/flp_cell.sv
rtl/four_pole_resonant_lowpass.sv
rtl/flp_chk.sv
sim/tb.sv
